FILE: rtl/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types and constants of the box blur unit.
// ----------------------------------------------------------------------------
package rbb_pkg;

    // Widths of the configuration registers.
    localparam int CFG_W        = 10;
    localparam int RADIUS_CFG_W = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int PIX_W        = 8;

    // Default limits of the frame and kernel.
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_RADIUS = 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

    // Reset values of the registers.
    localparam logic [CFG_W-1:0]        RST_WIDTH  = 10'd320;
    localparam logic [CFG_W-1:0]        RST_HEIGHT = 10'd240;
    localparam logic [RADIUS_CFG_W-1:0] RST_RADIUS = 2'd2;

    // Input commands.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPARE,
        ST_ACC,
        ST_DRAIN,
        ST_DIV,
        ST_HOLD
    } t_state;

    // Control of the channel lanes.
    typedef struct packed {
        logic clear;
        logic acc;
        logic load;
        logic step;
    } t_lane_ctl;

endpackage

FILE: rtl/rbb_store.sv
// ----------------------------------------------------------------------------
// rbb_store
// Circular pixel store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module rbb_store #(
    parameter int DEPTH  = 2565,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rbb_lane.sv
// ----------------------------------------------------------------------------
// rbb_lane
// One color channel: window accumulator and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module rbb_lane #(
    parameter int SUM_W = 13,
    parameter int DIV_W = 5
) (
    input  logic                   i_clk,
    input  rbb_pkg::t_lane_ctl     i_ctl,
    input  logic [rbb_pkg::PIX_W-1:0] i_pix,
    input  logic [DIV_W-1:0]       i_divisor,
    output logic [rbb_pkg::PIX_W-1:0] o_mean
);

    logic [SUM_W-1:0] r_acc;
    logic [SUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W:0]   rem2;
    logic             fits;

    // One quotient bit per step.
    always_comb begin
        rem2 = {r_rem, r_quo[SUM_W-1]};
        fits = (rem2 >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= r_acc + SUM_W'(i_pix);
        end
        if (i_ctl.load) begin
            r_quo <= r_acc;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? DIV_W'(rem2 - {1'b0, i_divisor}) : DIV_W'(rem2);
        end
    end

    assign o_mean = r_quo[rbb_pkg::PIX_W-1:0];

endmodule

FILE: rtl/rgb_box_blur_clamped_unit.sv
// Flow: the item that completes an output window walks that window with one store
// read per window pixel, drains the read pipeline, then divides with one quotient bit
// per cycle (SUM_W is 13 bits at the default radius limit of 2) and waits in the hold
// state until the output register is free. Throughput: one item at a time.
// Items without output pass check and compare, or only check once the frame is output.
// Reset (synchronous, active low) restores register defaults and restarts the frame.
// ----------------------------------------------------------------------------
// rgb_box_blur_clamped_unit
// Box blur with replicate border over a BGR raster stream, three channel lanes.
// ----------------------------------------------------------------------------
module rgb_box_blur_clamped_unit #(
    parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbb_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = rbb_pkg::DEF_MAX_RADIUS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rbb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_command,
    input  logic [rbb_pkg::PIX_W-1:0] i_blue_in,
    input  logic [rbb_pkg::PIX_W-1:0] i_green_in,
    input  logic [rbb_pkg::PIX_W-1:0] i_red_in,
    output logic o_valid,
    input  logic i_ready,
    output logic [rbb_pkg::PIX_W-1:0] o_blue_out,
    output logic [rbb_pkg::PIX_W-1:0] o_green_out,
    output logic [rbb_pkg::PIX_W-1:0] o_red_out,
    output logic o_frame_end
);

    localparam int PW     = rbb_pkg::PIX_W;
    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int DEPTH  = SIDE * MAX_WIDTH + SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WV_W   = $clog2(MAX_WIDTH + 1);
    localparam int HV_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int RV_W   = $clog2(MAX_RADIUS + 1);
    localparam int KW     = $clog2(SIDE);
    localparam int LIN_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUM_W  = $clog2(SIDE * SIDE * 255 + 1);
    localparam int DIV_W  = $clog2(SIDE * SIDE + 1);
    localparam int CNT_W  = $clog2(SUM_W);
    localparam int YE_W   = ROW_W + KW;
    localparam int XE_W   = COL_W + KW;

    // Configuration registers.
    logic [rbb_pkg::CFG_W-1:0]        r_cfg_w, r_cfg_h;
    logic [rbb_pkg::RADIUS_CFG_W-1:0] r_cfg_r;
    logic [WV_W-1:0] wv;
    logic [HV_W-1:0] hv;
    logic [RV_W-1:0] rv;
    logic [KW-1:0]   kmax;
    logic [DIV_W-1:0] divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= rbb_pkg::RST_WIDTH;
            r_cfg_h <= rbb_pkg::RST_HEIGHT;
            r_cfg_r <= rbb_pkg::RST_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbb_pkg::REG_WIDTH:  r_cfg_w <= i_cfg_data;
                rbb_pkg::REG_HEIGHT: r_cfg_h <= i_cfg_data;
                rbb_pkg::REG_RADIUS: r_cfg_r <= i_cfg_data[rbb_pkg::RADIUS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size and radius, clipped to the supported range.
    always_comb begin
        if (r_cfg_w == '0)                   wv = WV_W'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH)   wv = WV_W'(MAX_WIDTH);
        else                                 wv = WV_W'(r_cfg_w);
        if (r_cfg_h == '0)                   hv = HV_W'(1);
        else if (32'(r_cfg_h) > MAX_HEIGHT)  hv = HV_W'(MAX_HEIGHT);
        else                                 hv = HV_W'(r_cfg_h);
        if (32'(r_cfg_r) > MAX_RADIUS)       rv = RV_W'(MAX_RADIUS);
        else                                 rv = RV_W'(r_cfg_r);
        kmax    = KW'({rv, 1'b0});
        divisor = DIV_W'((KW'(kmax) + KW'(1)) * (KW'(kmax) + KW'(1)));
    end

    // Frame position state.
    rbb_pkg::t_state r_state, n_state;
    logic [ROW_W-1:0]  r_in_row, r_out_row;
    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [LIN_W-1:0]  r_in_lin, r_need;
    logic [ADDR_W-1:0] r_wptr;
    logic r_in_done, r_out_done;
    logic [KW-1:0] r_ky, r_kx;
    logic [CNT_W-1:0] r_dcnt;
    logic r_ov, r_fe;
    logic [PW-1:0] r_ob, r_og, r_or;

    // Window walk pipeline.
    logic [LIN_W-1:0]  r_lin;
    logic [ADDR_W-1:0] r_raddr;
    logic r_va, r_vb, r_vc;

    logic accept, is_pix, last_pix_of_frame;
    logic [ROW_W-1:0]  b_row;
    logic [COL_W-1:0]  b_col;
    logic [LIN_W-1:0]  b_lin;
    logic [ADDR_W-1:0] b_wptr;
    logic [ROW_W-1:0]  ny, yy;
    logic [COL_W-1:0]  nx, xx;
    logic [YE_W-1:0]   ysum;
    logic [XE_W-1:0]   xsum;
    logic [LIN_W-1:0]  lin_gap;
    logic [ADDR_W:0]   wrap_addr;
    logic out_take, out_free, last_k, out_last_col, out_last_row;
    rbb_pkg::t_lane_ctl lane_ctl;
    logic [3*PW-1:0] rdata;
    logic [PW-1:0]   mean_b, mean_g, mean_r;

    assign accept = i_valid && o_ready;
    assign is_pix = (i_command == rbb_pkg::CMD_PIXEL);

    // Starting point of a pixel: a new frame begins after a complete one.
    always_comb begin
        b_row  = r_in_done ? '0 : r_in_row;
        b_col  = r_in_done ? '0 : r_in_col;
        b_lin  = r_in_done ? '0 : r_in_lin;
        b_wptr = r_in_done ? '0 : r_wptr;
        last_pix_of_frame = (HV_W'(b_row) == hv - HV_W'(1)) &&
                            (WV_W'(b_col) == wv - WV_W'(1));
    end

    // Last window position needed by the next output.
    always_comb begin
        ysum = YE_W'(r_out_row) + YE_W'(rv);
        xsum = XE_W'(r_out_col) + XE_W'(rv);
        ny = (ysum < YE_W'(hv - HV_W'(1))) ? ROW_W'(ysum) : ROW_W'(hv - HV_W'(1));
        nx = (xsum < XE_W'(wv - WV_W'(1))) ? COL_W'(xsum) : COL_W'(wv - WV_W'(1));
    end

    // Clamped window coordinate for the current kernel offset.
    always_comb begin
        logic [YE_W-1:0] ty;
        logic [XE_W-1:0] tx;
        ty = YE_W'(r_out_row) + YE_W'(r_ky);
        tx = XE_W'(r_out_col) + XE_W'(r_kx);
        if (ty < YE_W'(rv))                        yy = '0;
        else if (ty - YE_W'(rv) > YE_W'(hv - HV_W'(1))) yy = ROW_W'(hv - HV_W'(1));
        else                                       yy = ROW_W'(ty - YE_W'(rv));
        if (tx < XE_W'(rv))                        xx = '0;
        else if (tx - XE_W'(rv) > XE_W'(wv - WV_W'(1))) xx = COL_W'(wv - WV_W'(1));
        else                                       xx = COL_W'(tx - XE_W'(rv));
    end

    // Store address: distance back from the write pointer, wrapped.
    always_comb begin
        lin_gap = r_in_lin - r_lin;
        if ((ADDR_W+1)'(r_wptr) >= (ADDR_W+1)'(lin_gap))
            wrap_addr = (ADDR_W+1)'(r_wptr) - (ADDR_W+1)'(lin_gap);
        else
            wrap_addr = (ADDR_W+1)'(r_wptr) + (ADDR_W+1)'(DEPTH) - (ADDR_W+1)'(lin_gap);
    end

    assign last_k       = (r_ky == kmax) && (r_kx == kmax);
    assign out_take     = r_ov && i_ready;
    assign out_free     = !r_ov || i_ready;
    assign out_last_col = (WV_W'(r_out_col) == wv - WV_W'(1));
    assign out_last_row = (HV_W'(r_out_row) == hv - HV_W'(1));

    // Next state and lane control.
    always_comb begin
        n_state  = r_state;
        lane_ctl = '0;
        case (r_state)
            rbb_pkg::ST_IDLE: begin
                if (accept) n_state = rbb_pkg::ST_CHECK;
            end
            rbb_pkg::ST_CHECK: begin
                n_state = r_out_done ? rbb_pkg::ST_IDLE : rbb_pkg::ST_COMPARE;
            end
            rbb_pkg::ST_COMPARE: begin
                if (r_need >= r_in_lin) begin
                    n_state = rbb_pkg::ST_IDLE;
                end else begin
                    n_state        = rbb_pkg::ST_ACC;
                    lane_ctl.clear = 1'b1;
                end
            end
            rbb_pkg::ST_ACC: begin
                lane_ctl.acc = r_vc;
                if (last_k) n_state = rbb_pkg::ST_DRAIN;
            end
            rbb_pkg::ST_DRAIN: begin
                lane_ctl.acc = r_vc;
                if (!r_va && !r_vb && !r_vc) begin
                    lane_ctl.load = 1'b1;
                    n_state       = rbb_pkg::ST_DIV;
                end
            end
            rbb_pkg::ST_DIV: begin
                lane_ctl.step = 1'b1;
                if (r_dcnt == CNT_W'(SUM_W - 1)) n_state = rbb_pkg::ST_HOLD;
            end
            rbb_pkg::ST_HOLD: begin
                if (out_free) n_state = rbb_pkg::ST_IDLE;
            end
            default: n_state = rbb_pkg::ST_IDLE;
        endcase
    end

    // State register and frame bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state    <= rbb_pkg::ST_IDLE;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_lin   <= '0;
            r_wptr     <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_in_done  <= 1'b0;
            r_out_done <= 1'b0;
            r_va       <= 1'b0;
            r_vb       <= 1'b0;
            r_vc       <= 1'b0;
            if (!i_rst_n) r_ov <= 1'b0;
            else if (out_take) r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            // Input side: store the pixel and advance the raster position.
            if (accept && is_pix) begin
                if (r_in_done) begin
                    r_out_row  <= '0;
                    r_out_col  <= '0;
                    r_out_done <= 1'b0;
                end
                r_in_lin <= b_lin + LIN_W'(1);
                r_wptr   <= (32'(b_wptr) == DEPTH - 1) ? '0 : b_wptr + ADDR_W'(1);
                if (WV_W'(b_col) == wv - WV_W'(1)) begin
                    r_in_col <= '0;
                    r_in_row <= last_pix_of_frame ? '0 : b_row + ROW_W'(1);
                end else begin
                    r_in_col <= b_col + COL_W'(1);
                    r_in_row <= b_row;
                end
                r_in_done <= last_pix_of_frame;
            end
            // Window walk: issue one window position per cycle.
            if (r_state == rbb_pkg::ST_COMPARE) begin
                r_ky <= '0;
                r_kx <= '0;
            end else if (r_state == rbb_pkg::ST_ACC) begin
                if (r_kx == kmax) begin
                    r_kx <= '0;
                    r_ky <= r_ky + KW'(1);
                end else begin
                    r_kx <= r_kx + KW'(1);
                end
            end
            r_va <= (r_state == rbb_pkg::ST_ACC);
            r_vb <= r_va;
            r_vc <= r_vb;
            // Divider step count.
            if (r_state == rbb_pkg::ST_DIV) r_dcnt <= r_dcnt + CNT_W'(1);
            else                            r_dcnt <= '0;
            // Output register and output raster position.
            if (r_state == rbb_pkg::ST_HOLD && out_free) begin
                r_ov <= 1'b1;
                r_fe <= out_last_col && out_last_row;
                r_ob <= mean_b;
                r_og <= mean_g;
                r_or <= mean_r;
                if (out_last_col) begin
                    r_out_col <= '0;
                    if (out_last_row) begin
                        r_out_row  <= '0;
                        r_out_done <= 1'b1;
                    end else begin
                        r_out_row <= r_out_row + ROW_W'(1);
                    end
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == rbb_pkg::ST_CHECK) begin
            r_need <= LIN_W'(ny * wv) + LIN_W'(nx);
        end
        r_lin   <= LIN_W'(yy * wv) + LIN_W'(xx);
        r_raddr <= ADDR_W'(wrap_addr);
    end

    rbb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (3 * PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && is_pix),
        .i_waddr (b_wptr),
        .i_wdata ({i_red_in, i_green_in, i_blue_in}),
        .i_raddr (r_raddr),
        .o_rdata (rdata)
    );

    // One lane per color channel.
    rbb_lane #(.SUM_W(SUM_W), .DIV_W(DIV_W)) u_lane_b (
        .i_clk(i_clk), .i_ctl(lane_ctl), .i_pix(rdata[PW-1:0]),
        .i_divisor(divisor), .o_mean(mean_b)
    );
    rbb_lane #(.SUM_W(SUM_W), .DIV_W(DIV_W)) u_lane_g (
        .i_clk(i_clk), .i_ctl(lane_ctl), .i_pix(rdata[2*PW-1:PW]),
        .i_divisor(divisor), .o_mean(mean_g)
    );
    rbb_lane #(.SUM_W(SUM_W), .DIV_W(DIV_W)) u_lane_r (
        .i_clk(i_clk), .i_ctl(lane_ctl), .i_pix(rdata[3*PW-1:2*PW]),
        .i_divisor(divisor), .o_mean(mean_r)
    );

    assign o_ready     = (r_state == rbb_pkg::ST_IDLE);
    assign o_valid     = r_ov;
    assign o_blue_out  = r_ob;
    assign o_green_out = r_og;
    assign o_red_out   = r_or;
    assign o_frame_end = r_fe;

endmodule

FILE: rtl/rbb_checker.sv
// ----------------------------------------------------------------------------
// rbb_checker
// Port-level checks of the box blur unit, bound to the top level.
// ----------------------------------------------------------------------------
module rbb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic [7:0] o_blue_out,
    input logic o_frame_end
);

    // A waiting result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_blue_out) && $stable(o_frame_end))
        else $error("output changed while stalled");

    // Reset leaves no result pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // One item in work at a time: ready drops after each input transfer.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while busy");

endmodule

bind rgb_box_blur_clamped_unit rbb_checker u_rbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_blue_out  (o_blue_out),
    .o_frame_end (o_frame_end)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the box blur unit. A directed table of frames and
// register writes comes first, then random frames of random size and radius
// with flush ticks mixed in. Every output transfer is compared with a
// behavioral predictor of the replicate-border mean filter, or with a value fixed in the table.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PIX_W        = rbb_pkg::PIX_W;
    localparam int CFG_W        = rbb_pkg::CFG_W;
    localparam int CFG_IDX_W    = rbb_pkg::CFG_IDX_W;
    localparam int RADIUS_CFG_W = rbb_pkg::RADIUS_CFG_W;
    localparam int HALF_PERIOD = 6;
    localparam int MAX_W       = rbb_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H       = rbb_pkg::DEF_MAX_HEIGHT;
    localparam int MAX_R       = rbb_pkg::DEF_MAX_RADIUS;
    localparam int RING_DEPTH  = (2 * MAX_R + 1) * MAX_W + 2 * MAX_R + 1;
    localparam int SETTLE_CYC  = 64;
    localparam int ITEM_TARGET = 1400;
    localparam int HOLD_CYC    = 400;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             frame_end;
    } t_blur_px;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic                 cmd;
        logic [PIX_W-1:0]     b, g, r;
        bit                   typed;
        t_blur_px             px;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_command = rbb_pkg::CMD_PIXEL;
    logic [PIX_W-1:0] i_blue_in = '0, i_green_in = '0, i_red_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [PIX_W-1:0] o_blue_out, o_green_out, o_red_out;
    logic o_frame_end;

    // Mirror of the filter state.
    logic [23:0] pix_ring [RING_DEPTH];
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [RADIUS_CFG_W-1:0] radius_reg;
    int unsigned in_y, in_x, out_y, out_x;
    bit in_full, out_full;

    t_blur_px blur_q[$];
    int err_cnt = 0;
    int mismatch_cnt = 0;
    int tx_idle = 0;
    int rx_idle = 0;
    int item_cnt = 0;
    bit hold_req = 0;

    rgb_box_blur_clamped_unit DUT (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Generous limit on the whole run.
    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned eff_w();
        if (width_reg == 0) return 1;
        return (width_reg > MAX_W) ? MAX_W : width_reg;
    endfunction

    function automatic int unsigned eff_h();
        if (height_reg == 0) return 1;
        return (height_reg > MAX_H) ? MAX_H : height_reg;
    endfunction

    function automatic int unsigned eff_r();
        return (radius_reg > MAX_R) ? MAX_R : radius_reg;
    endfunction

    function automatic void restart_frame();
        in_y = 0; in_x = 0; out_y = 0; out_x = 0;
        in_full = 0; out_full = 0;
    endfunction

    function automatic void mirror_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            rbb_pkg::REG_WIDTH:  width_reg = data;
            rbb_pkg::REG_HEIGHT: height_reg = data;
            rbb_pkg::REG_RADIUS: radius_reg = data[RADIUS_CFG_W-1:0];
            default: ;
        endcase
        restart_frame();
    endfunction

    // Advances the mirror by one accepted item; returns 1 with the blurred
    // pixel when the item releases an output.
    function automatic bit blur_step(logic cmd, logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                                     logic [PIX_W-1:0] r, output t_blur_px px);
        int unsigned w, h, rad, cnt, ny, nx, yy, xx, area, sb, sg, sr;
        int dy, dx;
        logic [23:0] p;
        w = eff_w(); h = eff_h(); rad = eff_r();
        sb = 0; sg = 0; sr = 0;
        px = '{default: '0};
        if (cmd == rbb_pkg::CMD_PIXEL) begin
            if (in_full) restart_frame();
            pix_ring[(in_y * w + in_x) % RING_DEPTH] = {r, g, b};
            if (++in_x >= w) begin
                in_x = 0;
                if (++in_y >= h) begin
                    in_y = 0;
                    in_full = 1;
                end
            end
        end
        if (out_full) return 0;
        cnt = in_full ? h * w : in_y * w + in_x;
        ny = (out_y + rad < h - 1) ? out_y + rad : h - 1;
        nx = (out_x + rad < w - 1) ? out_x + rad : w - 1;
        if (ny * w + nx >= cnt) return 0;
        for (dy = -int'(rad); dy <= int'(rad); dy++) begin
            for (dx = -int'(rad); dx <= int'(rad); dx++) begin
                yy = (int'(out_y) + dy < 0) ? 0 :
                     (int'(out_y) + dy > int'(h) - 1) ? h - 1 : out_y + dy;
                xx = (int'(out_x) + dx < 0) ? 0 :
                     (int'(out_x) + dx > int'(w) - 1) ? w - 1 : out_x + dx;
                p = pix_ring[(yy * w + xx) % RING_DEPTH];
                sb += p[7:0]; sg += p[15:8]; sr += p[23:16];
            end
        end
        area = (2 * rad + 1) * (2 * rad + 1);
        px.blue = PIX_W'(sb / area);
        px.green = PIX_W'(sg / area);
        px.red = PIX_W'(sr / area);
        if (++out_x >= w) begin
            out_x = 0;
            if (++out_y >= h) begin
                out_y = 0;
                out_full = 1;
                px.frame_end = 1;
            end
        end
        return 1;
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request.
    int hold_left = 0;
    bit hold_used = 0;
    always @(negedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_used = 1;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Check every output transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_blur_px want;
        if (i_rst_n && o_valid && i_ready) begin
            if (blur_q.size() == 0) begin
                err_cnt++;
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("Unexpected output transfer at %0t", $realtime);
            end else begin
                want = blur_q.pop_front();
                if (want.blue !== o_blue_out || want.green !== o_green_out ||
                    want.red !== o_red_out || want.frame_end !== o_frame_end) begin
                    err_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("Mismatch at %0t: expected b=%0d g=%0d r=%0d end=%0b",
                                 $realtime, want.blue, want.green, want.red,
                                 want.frame_end);
                        $display("    actual b=%0d g=%0d r=%0d end=%0b",
                                 o_blue_out, o_green_out, o_red_out, o_frame_end);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (blur_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Register write while the unit is idle; called at a falling edge.
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_valid <= 1'b0;
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        mirror_write(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one item and waits for its transfer; called at a falling edge.
    task automatic send_item(logic cmd, logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] r, bit typed = 0,
                             t_blur_px fixed = '{default: '0});
        t_blur_px px;
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_blue_in <= b;
        i_green_in <= g;
        i_red_in <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        item_cnt++;
        if (blur_step(cmd, b, g, r, px)) blur_q.push_back(typed ? fixed : px);
        @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // One random frame: optional new settings, pixels with flushes mixed in,
    // then a drain that is sometimes cut short.
    task automatic random_frame(bit big);
        int unsigned n, cut;
        if (big) begin
            case ($urandom_range(2))
                0: begin
                    set_reg(rbb_pkg::REG_WIDTH, 10'd512);
                    set_reg(rbb_pkg::REG_HEIGHT, 10'd1);
                end
                1: begin
                    set_reg(rbb_pkg::REG_WIDTH, 10'd1);
                    set_reg(rbb_pkg::REG_HEIGHT, 10'd512);
                end
                default: begin
                    set_reg(rbb_pkg::REG_WIDTH, 10'd1023);
                    set_reg(rbb_pkg::REG_HEIGHT, 10'd0);
                end
            endcase
            set_reg(rbb_pkg::REG_RADIUS, CFG_W'($urandom_range(3)));
        end else if ($urandom_range(1)) begin
            set_reg(rbb_pkg::REG_WIDTH, CFG_W'($urandom_range(10)));
            set_reg(rbb_pkg::REG_HEIGHT, CFG_W'($urandom_range(6)));
            set_reg(rbb_pkg::REG_RADIUS, CFG_W'($urandom_range(1023)));
            if ($urandom_range(9) == 0) set_reg(REG_NONE, CFG_W'($urandom_range(1023)));
        end
        n = eff_w() * eff_h();
        // Some frames are broken off part way.
        cut = ($urandom_range(9) == 0) ? $urandom_range(n) : n;
        for (int unsigned k = 0; k < cut; k++) begin
            if ($urandom_range(9) == 0)
                send_item(rbb_pkg::CMD_FLUSH, rand_chan(), rand_chan(), rand_chan());
            send_item(rbb_pkg::CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
        end
        if (cut < n) begin
            if ($urandom_range(1)) set_reg(REG_NONE, '0);
            return;
        end
        // Drain; now and then leave outputs pending for the next frame to drop.
        // A frame that continued a broken one may end with its input incomplete.
        if ($urandom_range(6) == 0) begin
            repeat ($urandom_range(2))
                send_item(rbb_pkg::CMD_FLUSH, rand_chan(), rand_chan(), rand_chan());
        end else begin
            while (in_full && !out_full)
                send_item(rbb_pkg::CMD_FLUSH, rand_chan(), rand_chan(), rand_chan());
            repeat ($urandom_range(2))
                send_item(rbb_pkg::CMD_FLUSH, rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    t_stim_row dir_rows[$];

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        t_stim_row row;
        row = '{kind: ROW_CFG, default: '0};
        row.idx = idx; row.data = data;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_item(logic cmd, logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                                     logic [PIX_W-1:0] r, bit typed = 0,
                                     logic [PIX_W-1:0] eb = '0, logic [PIX_W-1:0] eg = '0,
                                     logic [PIX_W-1:0] er = '0, logic efe = 1'b0);
        t_stim_row row;
        row = '{kind: ROW_ITEM, default: '0};
        row.cmd = cmd; row.b = b; row.g = g; row.r = r;
        row.typed = typed; row.px = '{eb, eg, er, efe};
        dir_rows.push_back(row);
    endfunction

    initial begin
        width_reg = rbb_pkg::RST_WIDTH;
        height_reg = rbb_pkg::RST_HEIGHT;
        radius_reg = rbb_pkg::RST_RADIUS;
        restart_frame();
        foreach (pix_ring[k]) pix_ring[k] = '0;

        // Single-pixel frames: the output equals the input.
        add_cfg(rbb_pkg::REG_WIDTH, 10'd1);
        add_cfg(rbb_pkg::REG_HEIGHT, 10'd1);
        add_cfg(rbb_pkg::REG_RADIUS, 10'd0);
        add_item(rbb_pkg::CMD_PIXEL, 8'd255, 8'd0, 8'd170, 1, 8'd255, 8'd0, 8'd170, 1'b1);
        add_item(rbb_pkg::CMD_FLUSH, 8'd255, 8'd255, 8'd255);
        add_item(rbb_pkg::CMD_PIXEL, 8'd0, 8'd255, 8'd85, 1, 8'd0, 8'd255, 8'd85, 1'b1);
        add_cfg(REG_NONE, 10'd1023);
        // Small frame: early flush, drain, then a pixel dropping what is pending.
        add_cfg(rbb_pkg::REG_WIDTH, 10'd3);
        add_cfg(rbb_pkg::REG_HEIGHT, 10'd2);
        add_cfg(rbb_pkg::REG_RADIUS, 10'd1);
        add_item(rbb_pkg::CMD_PIXEL, 8'd10, 8'd200, 8'd255);
        add_item(rbb_pkg::CMD_PIXEL, 8'd0, 8'd1, 8'd254);
        add_item(rbb_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0);
        add_item(rbb_pkg::CMD_PIXEL, 8'd255, 8'd128, 8'd7);
        add_item(rbb_pkg::CMD_PIXEL, 8'd90, 8'd255, 8'd0);
        add_item(rbb_pkg::CMD_PIXEL, 8'd33, 8'd66, 8'd99);
        add_item(rbb_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        add_item(rbb_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0);
        add_item(rbb_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0);
        add_item(rbb_pkg::CMD_PIXEL, 8'd1, 8'd2, 8'd3);
        // Out-of-range settings: radius 3 acts as 2, width 0 acts as 1.
        add_cfg(rbb_pkg::REG_RADIUS, 10'd3);
        add_cfg(rbb_pkg::REG_WIDTH, 10'd0);
        add_cfg(rbb_pkg::REG_HEIGHT, 10'd1);
        add_item(rbb_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255, 1,
                 8'd255, 8'd255, 8'd255, 1'b1);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG)
                set_reg(dir_rows[k].idx, dir_rows[k].data);
            else
                send_item(dir_rows[k].cmd, dir_rows[k].b, dir_rows[k].g, dir_rows[k].r,
                          dir_rows[k].typed, dir_rows[k].px);
        end

        // Three idling phases; the first carries the long receiver hold-off.
        for (int phase = 0; phase < 3; phase++) begin
            int frames;
            tx_idle = (phase == 0) ? 7 : (phase == 1) ? 57 : 0;
            rx_idle = (phase == 0) ? 57 : (phase == 1) ? 7 : 0;
            frames = 0;
            if (phase == 0) hold_req = 1;
            while (item_cnt < ITEM_TARGET * (phase + 1) / 3) begin
                random_frame(frames == 4);
                frames++;
                // Sender pauses until the block has caught up.
                if (frames == 2) begin
                    i_valid <= 1'b0;
                    wait_drained();
                end
            end
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rbb_pkg.sv
rtl/rbb_store.sv
rtl/rbb_lane.sv
rtl/rgb_box_blur_clamped_unit.sv
rtl/rbb_checker.sv
tb/sv/testbench.sv
